>>> rtl/sss_pkg.sv
// sss_pkg: shared types and constants for the scaled sparse sum-of-squares block.
// Used by every module under rtl/; depends on nothing.
package sss_pkg;

	localparam int COLUMNS_DEF = 1024;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] REG_SCALE_A = 2'd0;
	localparam logic [1:0] REG_SCALE_B = 2'd1;
	localparam logic [1:0] REG_LIMIT   = 2'd2;

	localparam logic signed [31:0] SCALE_RESET = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX       = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN       = 32'sh8000_0000;

	typedef enum logic [1:0] {
		ACT_LOAD_A = 2'd0,
		ACT_LOAD_B = 2'd1,
		ACT_FOLD   = 2'd2,
		ACT_EMIT   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		JOB_LOAD_A,
		JOB_LOAD_B,
		JOB_FOLD,
		JOB_EMIT
	} job_kind_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_RUN,
		BK_FOLD
	} back_state_t;

	typedef struct packed {
		action_t            action;
		logic [9:0]         column;
		logic signed [31:0] value;
	} request_t;

	typedef struct packed {
		logic [63:0] total;
		logic        saturated;
	} result_t;

	typedef struct packed {
		job_kind_t          kind;
		logic [9:0]         column;
		logic signed [31:0] value;
	} job_t;

	typedef struct packed {
		logic push;
		job_t data;
	} queue_wr_t;

	typedef struct packed {
		logic signed [31:0] scale_a;
		logic signed [31:0] scale_b;
		logic [30:0]        limit;
	} config_t;

endpackage

>>> rtl/sss_front.sv
// sss_front: request acceptance and classification into queue jobs.
// Depends on sss_pkg; feeds sss_queue.
module sss_front #(
	parameter int COLUMNS = sss_pkg::COLUMNS_DEF
) (
	input  logic                 start,
	input  sss_pkg::request_t    request,
	input  logic                 queue_full,
	input  logic                 clearing,
	output logic                 busy,
	output sss_pkg::queue_wr_t   queue_wr
);

	logic accept;
	logic in_range;

	assign busy     = queue_full | clearing;
	assign accept   = start & ~busy;
	assign in_range = 32'(request.column) < 32'(COLUMNS);

	always_comb begin
		queue_wr.data.column = request.column;
		queue_wr.data.value  = request.value;
		case (request.action)
			sss_pkg::ACT_LOAD_A: begin
				queue_wr.data.kind = sss_pkg::JOB_LOAD_A;
				queue_wr.push      = accept & in_range;
			end
			sss_pkg::ACT_LOAD_B: begin
				queue_wr.data.kind = sss_pkg::JOB_LOAD_B;
				queue_wr.push      = accept & in_range;
			end
			sss_pkg::ACT_FOLD: begin
				queue_wr.data.kind = sss_pkg::JOB_FOLD;
				queue_wr.push      = accept;
			end
			default: begin
				queue_wr.data.kind = sss_pkg::JOB_EMIT;
				queue_wr.push      = accept;
			end
		endcase
	end

endmodule

>>> rtl/sss_queue.sv
// sss_queue: short job queue between the front and the back end.
// Depends on sss_pkg.
module sss_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  sss_pkg::queue_wr_t wr,
	input  logic               pop,
	output sss_pkg::job_t      head,
	output logic               full,
	output logic               empty
);

	localparam int PTR_W = $clog2(sss_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(sss_pkg::QUEUE_DEPTH + 1);

	sss_pkg::job_t     slot_q [sss_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;

	assign head  = slot_q[rd_ptr_q];
	assign full  = fill_q == CNT_W'(sss_pkg::QUEUE_DEPTH);
	assign empty = fill_q == '0;

	always_ff @(posedge clk) begin
		if (wr.push) begin
			slot_q[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr.push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (!wr.push && pop) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/sss_back.sv
// sss_back: execution engine - entry load pipeline with forwarding, row fold walk,
// total emission and the post-reset clear of the column valid store. Depends on sss_pkg.
module sss_back #(
	parameter int COLUMNS = sss_pkg::COLUMNS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sss_pkg::config_t cfg,
	input  sss_pkg::job_t    head,
	input  logic             queue_empty,
	output logic             pop,
	output logic             clearing,
	output logic             result_valid,
	output sss_pkg::result_t result
);

	localparam int IW    = $clog2(COLUMNS);
	localparam int CNT_W = $clog2(COLUMNS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(COLUMNS - 1);

	sss_pkg::back_state_t state_q, state_d;

	logic [31:0]   row_mem  [COLUMNS];
	logic          used_mem [COLUMNS];
	logic [IW-1:0] tl_mem   [COLUMNS];

	logic [IW-1:0]    clr_idx_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] walk_q;

	logic               head_load;
	logic               pipe_busy;
	logic [IW-1:0]      head_col;
	logic signed [31:0] scale_sel;
	logic signed [63:0] prod_d;

	logic               valid_s1_q;
	logic [IW-1:0]      col_s1_q;
	logic signed [63:0] prod_s1_q;
	logic               rd_used_q;
	logic [31:0]        rd_row_q;

	logic signed [63:0] rounded;
	logic signed [63:0] shifted;
	logic [31:0]        scaled_d;
	logic               scale_sat_d;

	logic          valid_s2_q;
	logic [IW-1:0] col_s2_q;
	logic [31:0]   scaled_s2_q;
	logic          scale_sat_s2_q;
	logic          used_s2_q;
	logic [31:0]   row_s2_q;

	logic          h1_valid_q, h2_valid_q;
	logic [IW-1:0] h1_col_q, h2_col_q;
	logic [31:0]   h1_val_q, h2_val_q;

	logic          old_used;
	logic [31:0]   old_val;
	logic [32:0]   sum;
	logic          add_sat;
	logic [31:0]   new_val;

	logic          walk_more;
	logic          fold_done;
	logic          f1_q, f2_q, f3_q;
	logic [IW-1:0] tl_rd_q;
	logic [31:0]   mag;
	logic [63:0]   sq_d;
	logic [63:0]   sq_f3_q;
	logic          keep_f3_q;
	logic [64:0]   total_sum;
	logic [63:0]   total_q;
	logic          ovf_q;

	logic          result_valid_q;
	sss_pkg::result_t result_q;

	logic [IW-1:0] row_ra;
	logic          used_we;
	logic [IW-1:0] used_wa;
	logic          used_wd;
	logic          tl_we;

	assign head_load = (head.kind == sss_pkg::JOB_LOAD_A) || (head.kind == sss_pkg::JOB_LOAD_B);
	assign pipe_busy = valid_s1_q | valid_s2_q;
	assign head_col  = IW'(head.column);
	assign scale_sel = (head.kind == sss_pkg::JOB_LOAD_B) ? cfg.scale_b : cfg.scale_a;
	assign prod_d    = $signed(head.value) * $signed(scale_sel);

	assign walk_more = (state_q == sss_pkg::BK_FOLD) && (walk_q < count_q);
	assign fold_done = (walk_q == count_q) && !f1_q && !f2_q && !f3_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sss_pkg::BK_CLEAR: begin
				if (clr_idx_q == LAST_IDX) begin
					state_d = sss_pkg::BK_RUN;
				end
			end
			sss_pkg::BK_RUN: begin
				if (pop && head.kind == sss_pkg::JOB_FOLD && count_q != '0) begin
					state_d = sss_pkg::BK_FOLD;
				end
			end
			sss_pkg::BK_FOLD: begin
				if (fold_done) begin
					state_d = sss_pkg::BK_RUN;
				end
			end
			default: state_d = sss_pkg::BK_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		clearing = 1'b0;
		pop      = 1'b0;
		case (state_q)
			sss_pkg::BK_CLEAR: clearing = 1'b1;
			sss_pkg::BK_RUN:   pop = !queue_empty && (head_load || !pipe_busy);
			sss_pkg::BK_FOLD:  pop = 1'b0;
			default:           clearing = 1'b1;
		endcase
	end

	// round to nearest, then clamp to Q16.16
	always_comb begin
		rounded = prod_s1_q + 64'sd32768;
		shifted = rounded >>> 16;
		if ((&shifted[63:31]) || !(|shifted[63:31])) begin
			scaled_d    = shifted[31:0];
			scale_sat_d = 1'b0;
		end else begin
			scaled_d    = shifted[63] ? sss_pkg::Q_MIN : sss_pkg::Q_MAX;
			scale_sat_d = 1'b1;
		end
	end

	// forward the two writes the registered read missed
	always_comb begin
		if (h1_valid_q && h1_col_q == col_s2_q) begin
			old_used = 1'b1;
			old_val  = h1_val_q;
		end else if (h2_valid_q && h2_col_q == col_s2_q) begin
			old_used = 1'b1;
			old_val  = h2_val_q;
		end else begin
			old_used = used_s2_q;
			old_val  = row_s2_q;
		end
		sum     = {old_val[31], old_val} + {scaled_s2_q[31], scaled_s2_q};
		add_sat = old_used && (sum[32] != sum[31]);
		if (!old_used) begin
			new_val = scaled_s2_q;
		end else if (add_sat) begin
			new_val = sum[32] ? sss_pkg::Q_MIN : sss_pkg::Q_MAX;
		end else begin
			new_val = sum[31:0];
		end
	end

	always_comb begin
		mag       = rd_row_q[31] ? (32'd0 - rd_row_q) : rd_row_q;
		sq_d      = mag * mag;
		total_sum = {1'b0, total_q} + {1'b0, sq_f3_q};
	end

	always_comb begin
		row_ra  = (state_q == sss_pkg::BK_FOLD) ? tl_rd_q : head_col;
		used_we = 1'b0;
		used_wa = col_s2_q;
		used_wd = 1'b1;
		if (state_q == sss_pkg::BK_CLEAR) begin
			used_we = 1'b1;
			used_wa = clr_idx_q;
			used_wd = 1'b0;
		end else if (state_q == sss_pkg::BK_FOLD) begin
			used_we = f1_q;
			used_wa = tl_rd_q;
			used_wd = 1'b0;
		end else begin
			used_we = valid_s2_q;
		end
		tl_we = valid_s2_q && !old_used;
	end

	always_ff @(posedge clk) begin
		if (valid_s2_q) begin
			row_mem[col_s2_q] <= new_val;
		end
		rd_row_q <= row_mem[row_ra];
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_wa] <= used_wd;
		end
		rd_used_q <= used_mem[head_col];
	end

	always_ff @(posedge clk) begin
		if (tl_we) begin
			tl_mem[count_q[IW-1:0]] <= col_s2_q;
		end
		tl_rd_q <= tl_mem[walk_q[IW-1:0]];
	end

	// payload stages
	always_ff @(posedge clk) begin
		col_s1_q       <= head_col;
		prod_s1_q      <= prod_d;
		col_s2_q       <= col_s1_q;
		scaled_s2_q    <= scaled_d;
		scale_sat_s2_q <= scale_sat_d;
		used_s2_q      <= rd_used_q;
		row_s2_q       <= rd_row_q;
		h1_col_q       <= col_s2_q;
		h1_val_q       <= new_val;
		h2_col_q       <= h1_col_q;
		h2_val_q       <= h1_val_q;
		sq_f3_q        <= sq_d;
		keep_f3_q      <= mag > {1'b0, cfg.limit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sss_pkg::BK_CLEAR;
			clr_idx_q      <= '0;
			count_q        <= '0;
			walk_q         <= '0;
			valid_s1_q     <= 1'b0;
			valid_s2_q     <= 1'b0;
			h1_valid_q     <= 1'b0;
			h2_valid_q     <= 1'b0;
			f1_q           <= 1'b0;
			f2_q           <= 1'b0;
			f3_q           <= 1'b0;
			total_q        <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			valid_s1_q <= pop && head_load;
			valid_s2_q <= valid_s1_q;
			h1_valid_q <= valid_s2_q;
			h2_valid_q <= h1_valid_q;
			f1_q       <= walk_more;
			f2_q       <= f1_q;
			f3_q       <= f2_q;
			result_valid_q <= pop && head.kind == sss_pkg::JOB_EMIT;

			if (state_q == sss_pkg::BK_CLEAR) begin
				clr_idx_q <= clr_idx_q + IW'(1);
			end

			if (walk_more) begin
				walk_q <= walk_q + CNT_W'(1);
			end

			if (state_q == sss_pkg::BK_FOLD && fold_done) begin
				count_q <= '0;
				walk_q  <= '0;
			end else if (tl_we) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (pop && head.kind == sss_pkg::JOB_EMIT) begin
				total_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (f3_q && keep_f3_q) begin
					total_q <= total_sum[64] ? '1 : total_sum[63:0];
				end
				if ((f3_q && keep_f3_q && total_sum[64])
						|| (valid_s2_q && (scale_sat_s2_q || add_sat))) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == sss_pkg::JOB_EMIT) begin
			result_q.total     <= total_q;
			result_q.saturated <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> rtl/scaled_sparse_sum_squares_top.sv
// Flow: an accepted emit request is written to the job queue, popped by the back end once the
// load pipeline is empty, and its result strobe is registered. Loads enter the load pipeline
// one per cycle unless the back end is folding or clearing; the front takes one load request
// per cycle while busy is low. A row fold reads one touched-list entry per cycle; loads queue
// up to four deep behind a fold or emit. Reset: asynchronous, active low; then busy stays
// high while the column valid store is cleared. Results cannot be stalled by the receiver.
module scaled_sparse_sum_squares_top #(
	parameter int COLUMNS = sss_pkg::COLUMNS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sss_pkg::request_t request,
	output logic              result_valid,
	output sss_pkg::result_t  result,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [31:0]       wr_data
);

	sss_pkg::config_t   cfg_q;
	sss_pkg::queue_wr_t queue_wr;
	sss_pkg::job_t      head;
	logic               queue_full;
	logic               queue_empty;
	logic               pop;
	logic               clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_a <= sss_pkg::SCALE_RESET;
			cfg_q.scale_b <= sss_pkg::SCALE_RESET;
			cfg_q.limit   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				sss_pkg::REG_SCALE_A: cfg_q.scale_a <= wr_data;
				sss_pkg::REG_SCALE_B: cfg_q.scale_b <= wr_data;
				sss_pkg::REG_LIMIT:   cfg_q.limit   <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	sss_front #(
		.COLUMNS(COLUMNS)
	) u_front (
		.start     (start),
		.request   (request),
		.queue_full(queue_full),
		.clearing  (clearing),
		.busy      (busy),
		.queue_wr  (queue_wr)
	);

	sss_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (queue_wr),
		.pop   (pop),
		.head  (head),
		.full  (queue_full),
		.empty (queue_empty)
	);

	sss_back #(
		.COLUMNS(COLUMNS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.queue_empty (queue_empty),
		.pop         (pop),
		.clearing    (clearing),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

>>> rtl/sss_checker.sv
// sss_checker: port-level checks on the top level, bound to it below.
// Depends on sss_pkg and scaled_sparse_sum_squares_top.
module sss_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             busy,
	input logic             result_valid,
	input sss_pkg::result_t result
);

	// valid store clear holds requests off straight after reset
	a_busy_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> busy)
		else $error("busy low straight after reset");

	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !result_valid)
		else $error("result straight after reset");

	// two emits in a row: the second sees a cleared total
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid) |-> result.total == '0 && !result.saturated)
		else $error("total not cleared by emit");

endmodule

bind scaled_sparse_sum_squares_top sss_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.result_valid(result_valid),
	.result      (result)
);

>>> tb/sv/scaled_sparse_sum_squares_checker.sv
// Checker for the scaled sparse sum-of-squares block: watches the request, result and
// register-write ports, keeps its own row store and running total, and compares each result.
// Depends on sss_pkg; instantiated beside the block by scaled_sparse_sum_squares_top_tb.
module scaled_sparse_sum_squares_checker #(
	parameter int COLUMNS = sss_pkg::COLUMNS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  sss_pkg::request_t request,
	input  logic              result_valid,
	input  sss_pkg::result_t  result,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [31:0]       wr_data,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [63:0] WIDE_MAX = sss_pkg::Q_MAX;
	localparam logic signed [63:0] WIDE_MIN = sss_pkg::Q_MIN;

	logic signed [31:0] mult_a;
	logic signed [31:0] mult_b;
	logic [30:0]        keep_above;
	logic signed [31:0] row_acc [COLUMNS];
	bit                 col_live [COLUMNS];
	int                 live_cols [$];
	logic [63:0]        sumsq;
	bit                 sat_seen;
	sss_pkg::result_t   totals_due [$];

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > WIDE_MAX) begin
			sat_seen = 1'b1;
			return sss_pkg::Q_MAX;
		end
		if (v < WIDE_MIN) begin
			sat_seen = 1'b1;
			return sss_pkg::Q_MIN;
		end
		return v[31:0];
	endfunction

	// round to nearest, ties upward: floor((x*s + 2^15) / 2^16)
	function automatic logic signed [31:0] scale_q16(input logic signed [31:0] x,
			input logic signed [31:0] s);
		logic signed [63:0] xw;
		logic signed [63:0] sw;
		logic signed [63:0] p;
		xw = x;
		sw = s;
		p = xw * sw + 64'sd32768;
		return clamp32(p >>> 16);
	endfunction

	task automatic load_entry(input logic [9:0] c, input logic signed [31:0] x,
			input logic signed [31:0] s);
		logic signed [31:0] v;
		logic signed [63:0] acc;
		if (int'(c) >= COLUMNS)
			return;
		v = scale_q16(x, s);
		if (col_live[c]) begin
			acc = row_acc[c];
			acc = acc + v;
			row_acc[c] = clamp32(acc);
		end else begin
			row_acc[c] = v;
			col_live[c] = 1'b1;
			live_cols.push_back(int'(c));
		end
	endtask

	task automatic fold_row();
		logic signed [63:0] v;
		logic [63:0]        mag;
		logic [63:0]        sq;
		logic [64:0]        acc;
		foreach (live_cols[k]) begin
			v = row_acc[live_cols[k]];
			mag = (v < 0) ? -v : v;
			if (mag > {33'd0, keep_above}) begin
				sq = mag * mag;
				acc = {1'b0, sumsq} + {1'b0, sq};
				if (acc[64]) begin
					sumsq = '1;
					sat_seen = 1'b1;
				end else begin
					sumsq = acc[63:0];
				end
			end
			row_acc[live_cols[k]] = '0;
			col_live[live_cols[k]] = 1'b0;
		end
		live_cols.delete();
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sss_pkg::result_t due;
		if (!arst_n) begin
			mult_a = sss_pkg::SCALE_RESET;
			mult_b = sss_pkg::SCALE_RESET;
			keep_above = '0;
			for (int i = 0; i < COLUMNS; i++) begin
				row_acc[i] = '0;
				col_live[i] = 1'b0;
			end
			live_cols.delete();
			sumsq = '0;
			sat_seen = 1'b0;
			totals_due.delete();
			pending = 0;
		end else begin
			if (result_valid === 1'b1) begin
				if (totals_due.size() == 0) begin
					errors++;
					$error("unexpected result: total %h saturated %b",
						result.total, result.saturated);
				end else begin
					due = totals_due.pop_front();
					if (result.total !== due.total) begin
						errors++;
						$error("total: expected %h, got %h", due.total, result.total);
					end
					if (result.saturated !== due.saturated) begin
						errors++;
						$error("saturated: expected %b, got %b",
							due.saturated, result.saturated);
					end
				end
			end
			if (wr_en === 1'b1) begin
				case (wr_index)
					sss_pkg::REG_SCALE_A: mult_a = wr_data;
					sss_pkg::REG_SCALE_B: mult_b = wr_data;
					sss_pkg::REG_LIMIT:   keep_above = wr_data[30:0];
					default: ;
				endcase
			end
			if (start === 1'b1 && busy === 1'b0) begin
				case (request.action)
					sss_pkg::ACT_LOAD_A: load_entry(request.column, request.value, mult_a);
					sss_pkg::ACT_LOAD_B: load_entry(request.column, request.value, mult_b);
					sss_pkg::ACT_FOLD:   fold_row();
					default: begin
						due.total = sumsq;
						due.saturated = sat_seen;
						totals_due.push_back(due);
						sumsq = '0;
						sat_seen = 1'b0;
					end
				endcase
			end
			pending = totals_due.size();
		end
	end

endmodule

>>> tb/sv/scaled_sparse_sum_squares_top_tb.sv
// Testbench top for scaled_sparse_sum_squares_top: clock, reset, register writes and
// request stimulus under several idling phases; the checker module does all comparison.
// Depends on sss_pkg, the block under test and scaled_sparse_sum_squares_checker.
module scaled_sparse_sum_squares_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         COLUMNS         = sss_pkg::COLUMNS_DEF;
	localparam int         CYCLE_LIMIT     = 400000;
	localparam int         PHASES          = 8;
	localparam int         ITEMS_PER_PHASE = 60;
	localparam int         FULL_ROW_PHASE  = 5;
	localparam int         FULL_ROW_COLS   = 192;
	localparam logic [1:0] REG_SPARE       = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	sss_pkg::request_t request = '0;
	logic              result_valid;
	sss_pkg::result_t  result;
	logic              wr_en = 1'b0;
	logic [1:0]        wr_index = '0;
	logic [31:0]       wr_data = '0;

	int errors;
	int pending;
	int cycles = 0;
	int idle_pct = 0;
	int sent = 0;

	scaled_sparse_sum_squares_top #(.COLUMNS(COLUMNS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	scaled_sparse_sum_squares_checker #(.COLUMNS(COLUMNS)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// busy is sampled at the falling edge, where it holds the value the next rising edge sees
	task automatic issue(input sss_pkg::action_t a, input logic [9:0] c,
			input logic signed [31:0] v);
		sss_pkg::request_t r;
		bit                taken;
		r.action = a;
		r.column = c;
		r.value = v;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do begin
			@(negedge clk);
			taken = (busy === 1'b0);
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	// drain outstanding totals, then give any trailing fold time to finish
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (COLUMNS + 16) @(posedge clk);
	endtask

	task automatic set_config(input logic signed [31:0] sa, input logic signed [31:0] sb,
			input logic [30:0] lim);
		wr_en <= 1'b1;
		wr_index <= sss_pkg::REG_SCALE_A;
		wr_data <= sa;
		@(posedge clk);
		wr_index <= sss_pkg::REG_SCALE_B;
		wr_data <= sb;
		@(posedge clk);
		wr_index <= sss_pkg::REG_LIMIT;
		wr_data <= {1'($urandom_range(1)), lim};
		@(posedge clk);
		wr_index <= REG_SPARE;
		wr_data <= $urandom;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return sss_pkg::Q_MAX;
			1: return sss_pkg::Q_MIN;
			2: return '0;
			3: return $urandom_range(1) ? 32'sd1 : -32'sd1;
			4, 5: return $urandom;
			default: return int'($urandom_range(1 << 21)) - (1 << 20);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_scale();
		case ($urandom_range(7))
			0: return sss_pkg::SCALE_RESET;
			1: return sss_pkg::Q_MAX;
			2: return sss_pkg::Q_MIN;
			3: return '0;
			4: return 32'sh0000_8000;
			5: return -sss_pkg::SCALE_RESET;
			6: return $urandom;
			default: return int'($urandom_range(1 << 19)) - (1 << 18);
		endcase
	endfunction

	function automatic logic [30:0] pick_limit();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return 31'($urandom_range(1 << 20));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic random_rows(input int quota);
		int          first;
		int          width;
		logic [9:0]  c;
		int          cols [$];
		first = sent;
		while (sent - first < quota) begin
			repeat ($urandom_range(1, 4)) begin
				width = ($urandom_range(19) == 0) ? $urandom_range(16, 64) : $urandom_range(0, 8);
				cols.delete();
				repeat (width) begin
					if (cols.size() != 0 && $urandom_range(4) == 0) begin
						c = 10'(cols[$urandom_range(cols.size() - 1)]);
					end else begin
						c = 10'($urandom_range(COLUMNS - 1));
						cols.push_back(int'(c));
					end
					issue($urandom_range(1) ? sss_pkg::ACT_LOAD_B : sss_pkg::ACT_LOAD_A, c,
						pick_value());
				end
				// now and then leave the row unfolded across an emit
				if ($urandom_range(9) != 0)
					issue(sss_pkg::ACT_FOLD, 10'($urandom), $urandom);
			end
			issue(sss_pkg::ACT_EMIT, 10'($urandom), $urandom);
		end
	endtask

	task automatic full_row();
		int order [COLUMNS];
		int j;
		int t;
		for (int i = 0; i < COLUMNS; i++)
			order[i] = i;
		for (int i = COLUMNS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < FULL_ROW_COLS; i++)
			issue($urandom_range(1) ? sss_pkg::ACT_LOAD_B : sss_pkg::ACT_LOAD_A,
				10'(order[i]), int'($urandom_range(1 << 11)) - (1 << 10));
		issue(sss_pkg::ACT_FOLD, '0, '0);
		issue(sss_pkg::ACT_EMIT, '0, '0);
	endtask

	initial begin
		int idle_seq [4];
		idle_seq = '{0, 58, 0, 13};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);

		// reset settings: unity scales, nothing dropped
		issue(sss_pkg::ACT_EMIT, '1, '1);
		issue(sss_pkg::ACT_LOAD_A, 10'd0, sss_pkg::Q_MAX);
		issue(sss_pkg::ACT_LOAD_A, 10'd1023, sss_pkg::Q_MIN);
		issue(sss_pkg::ACT_LOAD_B, 10'd0, 32'sd1);
		issue(sss_pkg::ACT_LOAD_B, 10'd5, -32'sd1);
		issue(sss_pkg::ACT_LOAD_A, 10'd5, 32'sd1);
		issue(sss_pkg::ACT_FOLD, '0, '0);
		issue(sss_pkg::ACT_FOLD, '1, '1);
		issue(sss_pkg::ACT_EMIT, '0, '0);
		for (int i = 10; i < 15; i++)
			issue(sss_pkg::ACT_LOAD_A, 10'(i), sss_pkg::Q_MIN);
		issue(sss_pkg::ACT_FOLD, '0, '0);
		issue(sss_pkg::ACT_EMIT, '0, '0);
		issue(sss_pkg::ACT_LOAD_A, 10'd7, 32'sh0003_0000);
		issue(sss_pkg::ACT_EMIT, '0, '0);
		issue(sss_pkg::ACT_FOLD, '0, '0);
		issue(sss_pkg::ACT_EMIT, '0, '0);
		settle();

		set_config(sss_pkg::Q_MAX, sss_pkg::Q_MIN, '1);
		issue(sss_pkg::ACT_LOAD_A, 10'd3, sss_pkg::Q_MAX);
		issue(sss_pkg::ACT_LOAD_B, 10'd4, sss_pkg::Q_MAX);
		issue(sss_pkg::ACT_FOLD, '0, '0);
		issue(sss_pkg::ACT_EMIT, '0, '0);
		settle();

		// half scales: rounding ties go upward
		set_config(32'sh0000_8000, -32'sh0000_8000, '0);
		issue(sss_pkg::ACT_LOAD_A, 10'd2, 32'sd1);
		issue(sss_pkg::ACT_LOAD_B, 10'd2, 32'sd1);
		issue(sss_pkg::ACT_LOAD_A, 10'd9, -32'sd1);
		issue(sss_pkg::ACT_FOLD, '0, '0);
		issue(sss_pkg::ACT_EMIT, '0, '0);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_config(sss_pkg::Q_MIN, sss_pkg::Q_MAX, '0);
				1: set_config('0, sss_pkg::SCALE_RESET, '1);
				2: set_config(sss_pkg::SCALE_RESET, sss_pkg::SCALE_RESET, '0);
				default: set_config(pick_scale(), pick_scale(), pick_limit());
			endcase
			idle_pct = idle_seq[p % 4];
			if (p == FULL_ROW_PHASE)
				full_row();
			random_rows(ITEMS_PER_PHASE);
			settle();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
